// ===== sv/pid_heading_with_drift_trim_macros.svh =====
// Assertion helpers shared by the heading controller files.
`ifndef PID_HEADING_WITH_DRIFT_TRIM_MACROS_SVH
`define PID_HEADING_WITH_DRIFT_TRIM_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pdt_pkg.sv =====
`timescale 1ns / 1ps

package pdt_pkg;

    localparam int DEF_GAIN_FRAC_BITS = 8;
    localparam int DEF_SUM_WIDTH      = 40;

    localparam int ANGLE_W    = 16;
    localparam int TIME_W     = 32;
    localparam int ERR_W      = 32;
    localparam int DERIV_W    = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int MAXP_W     = 7;
    localparam int PERIOD_W   = 16;
    localparam int DRIVE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_PERIOD  = 3'd5;

    // Register values after reset.
    localparam logic [MAXP_W-1:0]          RST_MAX_POWER    = 7'd127;
    localparam logic signed [ANGLE_W-1:0]  RST_TARGET_ANGLE = 16'sd0;
    localparam logic signed [GAIN_W-1:0]   RST_GAIN_P       = 16'sd256;
    localparam logic signed [GAIN_W-1:0]   RST_GAIN_I       = 16'sd0;
    localparam logic signed [GAIN_W-1:0]   RST_GAIN_D       = 16'sd0;
    localparam logic [PERIOD_W-1:0]        RST_TRIM_PERIOD  = 16'd1500;

    typedef struct packed {
        logic [MAXP_W-1:0]         max_power;
        logic signed [ANGLE_W-1:0] target_angle;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [PERIOD_W-1:0]       trim_period_ms;
    } t_cfg;

    // Load strobes for the two register levels of the output stage.
    typedef struct packed {
        logic load_acc;
        logic load_out;
    } t_post_ctl;

endpackage

// ===== sv/pdt_if.sv =====
`timescale 1ns / 1ps

interface pdt_in_if import pdt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] gyro_angle;
    logic [TIME_W-1:0]         time_ms;

    modport source (output valid, output gyro_angle, output time_ms, input ready);
    modport sink   (input valid, input gyro_angle, input time_ms, output ready);
endinterface

interface pdt_out_if import pdt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface pdt_cfg_if import pdt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pdt_cfg_regs.sv =====
`timescale 1ns / 1ps

module pdt_cfg_regs import pdt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pdt_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_power      <= RST_MAX_POWER;
            r_cfg.target_angle   <= RST_TARGET_ANGLE;
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.trim_period_ms <= RST_TRIM_PERIOD;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_POWER:    r_cfg.max_power      <= i_cfg.data[MAXP_W-1:0];
                REG_TARGET_ANGLE: r_cfg.target_angle   <= i_cfg.data;
                REG_GAIN_P:       r_cfg.gain_p         <= i_cfg.data;
                REG_GAIN_I:       r_cfg.gain_i         <= i_cfg.data;
                REG_GAIN_D:       r_cfg.gain_d         <= i_cfg.data;
                REG_TRIM_PERIOD:  r_cfg.trim_period_ms <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/pdt_err_stage.sv =====
`timescale 1ns / 1ps
`include "pid_heading_with_drift_trim_macros.svh"

module pdt_err_stage import pdt_pkg::*; #(
    parameter int SUM_WIDTH = DEF_SUM_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic signed [ANGLE_W-1:0]   i_angle,
    input  logic [TIME_W-1:0]           i_time,
    input  t_cfg                        i_cfg,
    output logic signed [ERR_W-1:0]     o_err,
    output logic signed [SUM_WIDTH-1:0] o_sum,
    output logic signed [DERIV_W-1:0]   o_deriv
);

    localparam int FULL_W = ERR_W + 2;
    localparam int ADD_W  = ((SUM_WIDTH > ERR_W) ? SUM_WIDTH : ERR_W) + 1;
    localparam logic signed [ADD_W-1:0] SUM_HI =
        {{(ADD_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [ADD_W-1:0] SUM_LO = ~SUM_HI;
    localparam logic signed [ERR_W-1:0] ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [ERR_W-1:0] DRIFT_MIN = ERR_MIN;

    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [ERR_W-1:0]     r_prev;
    logic signed [ERR_W-1:0]     r_drift;
    logic [TIME_W-1:0]           r_base;
    logic                        r_loaded;
    logic signed [DERIV_W-1:0]   r_deriv;

    logic signed [FULL_W-1:0]    w_err_full;
    logic signed [ERR_W-1:0]     w_err;
    logic signed [ADD_W-1:0]     w_sum_full;
    logic signed [SUM_WIDTH-1:0] w_sum;
    logic [TIME_W-1:0]           w_base;
    logic [TIME_W-1:0]           w_elapsed;
    logic                        w_trim;

    always_comb begin
        // Exact error, then saturated to 32 bits.
        w_err_full = {{(FULL_W-ANGLE_W){i_cfg.target_angle[ANGLE_W-1]}}, i_cfg.target_angle}
                   - {{(FULL_W-ANGLE_W){i_angle[ANGLE_W-1]}}, i_angle}
                   - {{(FULL_W-ERR_W){r_drift[ERR_W-1]}}, r_drift};
        if ((w_err_full[FULL_W-1:ERR_W-1] == '0) || (w_err_full[FULL_W-1:ERR_W-1] == '1)) begin
            w_err = w_err_full[ERR_W-1:0];
        end else if (w_err_full[FULL_W-1]) begin
            w_err = ERR_MIN;
        end else begin
            w_err = ERR_MAX;
        end

        w_sum_full = {{(ADD_W-SUM_WIDTH){r_sum[SUM_WIDTH-1]}}, r_sum}
                   + {{(ADD_W-ERR_W){w_err[ERR_W-1]}}, w_err};
        if (w_sum_full > SUM_HI) begin
            w_sum = SUM_HI[SUM_WIDTH-1:0];
        end else if (w_sum_full < SUM_LO) begin
            w_sum = SUM_LO[SUM_WIDTH-1:0];
        end else begin
            w_sum = w_sum_full[SUM_WIDTH-1:0];
        end

        // The first sample after reset becomes the time base.
        w_base    = r_loaded ? r_base : i_time;
        w_elapsed = i_time - w_base;
        w_trim    = (w_elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, i_cfg.trim_period_ms});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_prev   <= '0;
            r_drift  <= '0;
            r_base   <= '0;
            r_loaded <= 1'b0;
        end else if (i_load) begin
            r_sum    <= w_sum;
            r_prev   <= w_err;
            r_loaded <= 1'b1;
            if (w_trim) begin
                r_base <= i_time;
                if (r_drift != DRIFT_MIN) begin
                    r_drift <= r_drift - 32'sd1;
                end
            end else if (!r_loaded) begin
                r_base <= i_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_deriv <= {w_err[ERR_W-1], w_err} - {r_prev[ERR_W-1], r_prev};
        end
    end

    // The stored error and sum are the values of the item now in this stage.
    assign o_err   = r_prev;
    assign o_sum   = r_sum;
    assign o_deriv = r_deriv;

    `PDT_ASSERT_NEXT(a_drift_step, i_clk, i_rst_n, 1'b1, (r_drift == $past(r_drift)) || (r_drift == ($past(r_drift) - 32'sd1)), "drift offset moved by more than one step")
    `PDT_ASSERT_NEXT(a_state_idle, i_clk, i_rst_n, !i_load, $stable(r_drift) && $stable(r_sum) && $stable(r_base), "controller state changed without an item")
    `PDT_ASSERT_NEXT(a_base_sticky, i_clk, i_rst_n, r_loaded, r_loaded, "time base flag dropped")

endmodule

// ===== sv/pdt_mult_stage.sv =====
`timescale 1ns / 1ps

module pdt_mult_stage import pdt_pkg::*; #(
    parameter int SUM_WIDTH = DEF_SUM_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic signed [ERR_W-1:0]              i_err,
    input  logic signed [SUM_WIDTH-1:0]          i_sum,
    input  logic signed [DERIV_W-1:0]            i_deriv,
    input  t_cfg                                 i_cfg,
    output logic signed [GAIN_W+ERR_W-1:0]       o_prod_p,
    output logic signed [GAIN_W+DERIV_W-1:0]     o_prod_d,
    output logic signed [GAIN_W+SUM_WIDTH/2:0]   o_prod_il,
    output logic signed [GAIN_W+SUM_WIDTH-SUM_WIDTH/2-1:0] o_prod_ih
);

    localparam int LO_W = SUM_WIDTH / 2;
    localparam int HI_W = SUM_WIDTH - LO_W;

    // The integral term is split in two halves to keep each multiplier narrow.
    logic signed [LO_W:0]   w_sum_lo;
    logic signed [HI_W-1:0] w_sum_hi;

    logic signed [GAIN_W+ERR_W-1:0]   r_prod_p;
    logic signed [GAIN_W+DERIV_W-1:0] r_prod_d;
    logic signed [GAIN_W+LO_W:0]      r_prod_il;
    logic signed [GAIN_W+HI_W-1:0]    r_prod_ih;

    assign w_sum_lo = {1'b0, i_sum[LO_W-1:0]};
    assign w_sum_hi = i_sum[SUM_WIDTH-1:LO_W];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod_p  <= i_cfg.gain_p * i_err;
            r_prod_d  <= i_cfg.gain_d * i_deriv;
            r_prod_il <= i_cfg.gain_i * w_sum_lo;
            r_prod_ih <= i_cfg.gain_i * w_sum_hi;
        end
    end

    assign o_prod_p  = r_prod_p;
    assign o_prod_d  = r_prod_d;
    assign o_prod_il = r_prod_il;
    assign o_prod_ih = r_prod_ih;

endmodule

// ===== sv/pdt_post.sv =====
`timescale 1ns / 1ps

module pdt_post import pdt_pkg::*; #(
    parameter int SUM_WIDTH      = DEF_SUM_WIDTH,
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  t_post_ctl                            i_ctl,
    input  logic signed [GAIN_W+ERR_W-1:0]       i_prod_p,
    input  logic signed [GAIN_W+DERIV_W-1:0]     i_prod_d,
    input  logic signed [GAIN_W+SUM_WIDTH/2:0]   i_prod_il,
    input  logic signed [GAIN_W+SUM_WIDTH-SUM_WIDTH/2-1:0] i_prod_ih,
    input  logic [MAXP_W-1:0]                    i_max_power,
    output logic signed [DRIVE_W-1:0]            o_drive,
    output logic                                 o_clamped
);

    localparam int LO_W  = SUM_WIDTH / 2;
    localparam int HI_W  = SUM_WIDTH - LO_W;
    localparam int ACC_W = (SUM_WIDTH + 18 > 52) ? SUM_WIDTH + 18 : 52;
    localparam int P_W   = GAIN_W + ERR_W;
    localparam int D_W   = GAIN_W + DERIV_W;
    localparam int IL_W  = GAIN_W + LO_W + 1;
    localparam int IH_W  = GAIN_W + HI_W;
    localparam logic signed [ACC_W-1:0] BIAS =
        (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);

    logic signed [ACC_W-1:0]   r_acc;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_clamped;

    logic signed [ACC_W-1:0]   w_ih_ext;
    logic signed [ACC_W-1:0]   w_biased;
    logic signed [ACC_W-1:0]   w_raw;
    logic signed [ACC_W-1:0]   w_lim;
    logic signed [ACC_W-1:0]   w_nlim;
    logic signed [DRIVE_W-1:0] w_lim_d;
    logic signed [DRIVE_W-1:0] w_drive;
    logic                      w_clamped;

    assign w_ih_ext = {{(ACC_W-IH_W){i_prod_ih[IH_W-1]}}, i_prod_ih};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_acc) begin
            r_acc <= {{(ACC_W-P_W){i_prod_p[P_W-1]}}, i_prod_p}
                   + {{(ACC_W-D_W){i_prod_d[D_W-1]}}, i_prod_d}
                   + {{(ACC_W-IL_W){i_prod_il[IL_W-1]}}, i_prod_il}
                   + (w_ih_ext <<< LO_W);
        end
    end

    always_comb begin
        // Division by a power of two, rounded toward zero.
        w_biased  = r_acc + (r_acc[ACC_W-1] ? BIAS : '0);
        w_raw     = w_biased >>> GAIN_FRAC_BITS;
        w_lim     = {{(ACC_W-MAXP_W){1'b0}}, i_max_power};
        w_nlim    = -w_lim;
        w_lim_d   = {{(DRIVE_W-MAXP_W){1'b0}}, i_max_power};
        w_clamped = 1'b1;
        if (w_raw > w_lim) begin
            w_drive = w_lim_d;
        end else if (w_raw < w_nlim) begin
            w_drive = -w_lim_d;
        end else begin
            w_drive   = w_raw[DRIVE_W-1:0];
            w_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_drive   <= w_drive;
            r_clamped <= w_clamped;
        end
    end

    assign o_drive   = r_drive;
    assign o_clamped = r_clamped;

endmodule

// ===== sv/pid_heading_with_drift_trim.sv =====
`timescale 1ns / 1ps
`include "pid_heading_with_drift_trim_macros.svh"
// Channel   Dir  Beat contents                          Handshake
// i_in      in   gyro_angle (s16), time_ms (u32)        valid / ready
// o_out     out  drive (s8), clamped (1)                valid / ready
// i_cfg     in   index (3), data (16)                   valid / ready, ready held high
//
// One beat is accepted every cycle unless all levels hold a beat and the output is stalled.
// The five register levels are input, error and state update, products, sum, clamp.
// Reset is synchronous and active low; it clears the controller state and all valid flags.
// A stalled output holds its beat while earlier levels keep filling their empty slots;
// the input is refused only when all five levels hold a beat and the output is stalled.

module pid_heading_with_drift_trim import pdt_pkg::*; #(
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
    parameter int SUM_WIDTH      = DEF_SUM_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdt_in_if.sink      i_in,
    pdt_out_if.source   o_out,
    pdt_cfg_if.sink     i_cfg
);

    localparam int LO_W  = SUM_WIDTH / 2;
    localparam int HI_W  = SUM_WIDTH - LO_W;
    localparam int NSTG  = 5;

    t_cfg w_cfg;

    // Input register level.
    logic signed [ANGLE_W-1:0] r_angle;
    logic [TIME_W-1:0]         r_time;

    // One valid flag per register level; level NSTG-1 is the output register.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_load;

    logic signed [ERR_W-1:0]          w_err;
    logic signed [SUM_WIDTH-1:0]      w_sum;
    logic signed [DERIV_W-1:0]        w_deriv;
    logic signed [GAIN_W+ERR_W-1:0]   w_prod_p;
    logic signed [GAIN_W+DERIV_W-1:0] w_prod_d;
    logic signed [GAIN_W+LO_W:0]      w_prod_il;
    logic signed [GAIN_W+HI_W-1:0]    w_prod_ih;
    t_post_ctl                        w_post_ctl;

    // A level may load when it is empty or when its beat moves on in the same cycle.
    always_comb begin
        w_load[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
    end

    assign i_in.ready = w_load[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_load[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0] && i_in.valid) begin
            r_angle <= i_in.gyro_angle;
            r_time  <= i_in.time_ms;
        end
    end

    pdt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // The controller state advances only when a real beat enters the error level.
    pdt_err_stage #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load[1] && r_vld[0]),
        .i_angle (r_angle),
        .i_time  (r_time),
        .i_cfg   (w_cfg),
        .o_err   (w_err),
        .o_sum   (w_sum),
        .o_deriv (w_deriv)
    );

    pdt_mult_stage #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_mult (
        .i_clk     (i_clk),
        .i_load    (w_load[2] && r_vld[1]),
        .i_err     (w_err),
        .i_sum     (w_sum),
        .i_deriv   (w_deriv),
        .i_cfg     (w_cfg),
        .o_prod_p  (w_prod_p),
        .o_prod_d  (w_prod_d),
        .o_prod_il (w_prod_il),
        .o_prod_ih (w_prod_ih)
    );

    assign w_post_ctl.load_acc = w_load[3] && r_vld[2];
    assign w_post_ctl.load_out = w_load[4] && r_vld[3];

    pdt_post #(
        .SUM_WIDTH      (SUM_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_post (
        .i_clk       (i_clk),
        .i_ctl       (w_post_ctl),
        .i_prod_p    (w_prod_p),
        .i_prod_d    (w_prod_d),
        .i_prod_il   (w_prod_il),
        .i_prod_ih   (w_prod_ih),
        .i_max_power (w_cfg.max_power),
        .o_drive     (o_out.drive),
        .o_clamped   (o_out.clamped)
    );

    assign o_out.valid = r_vld[NSTG-1];

    `PDT_ASSERT_NEXT(a_in_to_first, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0], "accepted beat did not reach the input register")
    `PDT_ASSERT_SAME(a_refuse_when_full, i_clk, i_rst_n, !i_in.ready, (&r_vld) && !o_out.ready, "input refused while a level was free")
    `PDT_ASSERT_NEXT(a_last_to_out, i_clk, i_rst_n, r_vld[NSTG-2] && w_load[NSTG-1], r_vld[NSTG-1], "beat lost on its way to the output register")

endmodule
